@@ hw/rtl/brvg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and rounding helpers for the beam ribbon vertex generator.
// No dependencies; every other file imports this package.
package brvg_pkg;

  localparam int MAX_SEGMENTS = 31;
  localparam int UNIT_SHIFT   = 30;

  // Configuration register indexes
  localparam logic [1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [1:0] CFG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic        [30:0] half_width;
    logic        [4:0]  segment_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic        [4:0]  point_index;
    logic               side;
    logic               degenerate;
    logic               last;
  } out_item_t;

  // Classified segment as it travels from the front to the back
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [32:0] diff_x;
    logic signed [32:0] diff_y;
    logic signed [32:0] diff_z;
    logic        [30:0] half_width;
    logic        [4:0]  count;
  } job_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cam_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // v / 2^30 rounded to nearest, ties away from zero
  function automatic logic signed [34:0] shr30_round(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
    return v[63] ? -$signed(r[34:0]) : $signed(r[34:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/brvg_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts segment beats, clamps the count and forms the axis difference.
// Depends on brvg_pkg.
module brvg_front import brvg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic hold_q, hold_d;
  job_t job_q, job_d;
  logic accept;

  assign in_ready_o = !hold_q || !full_i;
  assign push_o     = hold_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign job_o      = job_q;

  always_comb begin
    logic [4:0] cnt;
    cnt = in_data_i.segment_count;
    if (cnt == 5'd0) begin
      cnt = 5'd1;
    end else if (cnt > 5'(MAX_SEGMENTS)) begin
      cnt = 5'(MAX_SEGMENTS);
    end
    job_d.start_x    = in_data_i.start_x;
    job_d.start_y    = in_data_i.start_y;
    job_d.start_z    = in_data_i.start_z;
    job_d.diff_x     = 33'(in_data_i.end_x) - 33'(in_data_i.start_x);
    job_d.diff_y     = 33'(in_data_i.end_y) - 33'(in_data_i.start_y);
    job_d.diff_z     = 33'(in_data_i.end_z) - 33'(in_data_i.start_z);
    job_d.half_width = in_data_i.half_width;
    job_d.count      = cnt;
    hold_d = accept || (hold_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

@@ hw/rtl/brvg_fifo.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified segments between front and back.
// Depends on brvg_pkg.
module brvg_fifo import brvg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

@@ hw/rtl/brvg_div.sv @@
`timescale 1ns / 1ps
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on brvg_pkg.
module brvg_div import brvg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [31:0] den_q, den_d;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

  always_comb begin
    logic [32:0] rem_sh;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_sh = {rem_q, num_q[63]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 32'd0;
      num_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract where it fits
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 32'(rem_sh - {1'b0, den_q});
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

endmodule

@@ hw/rtl/brvg_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer over a shared multiplier, square root and the divider; emits vertices.
// Depends on brvg_pkg and a brvg_div instance in the top level.
module brvg_back import brvg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cam_t      cam_i,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAG   = 4'd1;
  localparam logic [3:0] ST_NORM  = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_UDONE = 4'd6;
  localparam logic [3:0] ST_PMUL  = 4'd7;
  localparam logic [3:0] ST_PDIR  = 4'd8;
  localparam logic [3:0] ST_CROSS = 4'd9;
  localparam logic [3:0] ST_OFF   = 4'd10;
  localparam logic [3:0] ST_EMIT0 = 4'd11;
  localparam logic [3:0] ST_EMIT1 = 4'd12;

  logic [3:0]  state_q, state_d;
  logic [1:0]  k_q, k_d;
  logic [1:0]  ph_q, ph_d;
  logic [2:0]  jx_q, jx_d;
  logic [4:0]  i_q, i_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        axis_mode_q, axis_mode_d;
  logic        zero_q, zero_d;
  logic        pneg_q, pneg_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic signed [31:0] s_q    [3];
  logic signed [31:0] s_d    [3];
  logic signed [32:0] diff_q [3];
  logic signed [32:0] diff_d [3];
  logic signed [32:0] vec_q  [3];
  logic signed [32:0] vec_d  [3];
  logic        [32:0] m_q    [3];
  logic        [32:0] m_d    [3];
  logic signed [31:0] ures_q [3];
  logic signed [31:0] ures_d [3];
  logic signed [31:0] axis_q [3];
  logic signed [31:0] axis_d [3];
  logic signed [31:0] p_q    [3];
  logic signed [31:0] p_d    [3];
  logic signed [32:0] cr_q   [3];
  logic signed [32:0] cr_d   [3];
  logic signed [34:0] off_q  [3];
  logic signed [34:0] off_d  [3];
  logic signed [31:0] cam    [3];

  logic        [30:0] w_q, w_d;
  logic        [32:0] top_q, top_d;
  logic        [61:0] sum_q, sum_d;
  logic        [62:0] res_q, res_d;
  logic        [62:0] bit_q, bit_d;
  logic signed [61:0] tmp_q, tmp_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, prod_d;
  logic        [63:0] prod_mag;
  logic               slot_free;

  assign cam[0] = cam_i.x;
  assign cam[1] = cam_i.y;
  assign cam[2] = cam_i.z;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign prod_mag    = prod_q[65] ? 64'(-prod_q) : 64'(prod_q);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = $signed({3'b0, m_q[k_q][29:0]});
        mul_b = $signed({3'b0, m_q[k_q][29:0]});
      end
      ST_PMUL: begin
        mul_a = diff_q[k_q];
        mul_b = $signed({28'b0, i_q});
      end
      ST_CROSS: begin
        case (jx_q)
          3'd0: begin mul_a = 33'(ures_q[1]); mul_b = 33'(axis_q[2]); end
          3'd1: begin mul_a = 33'(ures_q[2]); mul_b = 33'(axis_q[1]); end
          3'd2: begin mul_a = 33'(ures_q[2]); mul_b = 33'(axis_q[0]); end
          3'd3: begin mul_a = 33'(ures_q[0]); mul_b = 33'(axis_q[2]); end
          3'd4: begin mul_a = 33'(ures_q[0]); mul_b = 33'(axis_q[1]); end
          3'd5: begin mul_a = 33'(ures_q[1]); mul_b = 33'(axis_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_OFF: begin
        mul_a = $signed({2'b0, w_q});
        mul_b = cr_q[k_q];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // divider request
  always_comb begin
    div_req_o.start = 1'b0;
    div_req_o.num   = '0;
    div_req_o.den   = '0;
    if (state_q == ST_DIV) begin
      div_req_o.start = (ph_q == 2'd0);
      div_req_o.num   = {4'b0, m_q[k_q][29:0], 30'b0} + {33'b0, res_q[31:1]};
      div_req_o.den   = res_q[31:0];
    end else if (state_q == ST_PMUL) begin
      div_req_o.start = (ph_q == 2'd1);
      div_req_o.num   = prod_mag + {60'b0, cnt_q[4:1]};
      div_req_o.den   = {27'b0, cnt_q};
    end
  end

  always_comb begin
    logic [63:0]        rb;
    logic [32:0]        q;
    logic signed [33:0] psum;
    logic signed [63:0] xd;
    logic signed [35:0] pv;
    logic signed [35:0] ov;

    state_d     = state_q;
    k_d         = k_q;
    ph_d        = ph_q;
    jx_d        = jx_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    axis_mode_d = axis_mode_q;
    zero_d      = zero_q;
    pneg_d      = pneg_q;
    w_d         = w_q;
    top_d       = top_q;
    sum_d       = sum_q;
    res_d       = res_q;
    bit_d       = bit_q;
    tmp_d       = tmp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    for (int n = 0; n < 3; n++) begin
      s_d[n]    = s_q[n];
      diff_d[n] = diff_q[n];
      vec_d[n]  = vec_q[n];
      m_d[n]    = m_q[n];
      ures_d[n] = ures_q[n];
      axis_d[n] = axis_q[n];
      p_d[n]    = p_q[n];
      cr_d[n]   = cr_q[n];
      off_d[n]  = off_q[n];
    end
    rb   = {1'b0, res_q} + {1'b0, bit_q};
    q    = div_rsp_i.quo[32:0];
    psum = '0;
    xd   = $signed({{2{tmp_q[61]}}, tmp_q}) - $signed({{2{prod_q[61]}}, prod_q[61:0]});
    pv   = '0;
    ov   = '0;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          s_d[0]      = job_i.start_x;
          s_d[1]      = job_i.start_y;
          s_d[2]      = job_i.start_z;
          diff_d[0]   = job_i.diff_x;
          diff_d[1]   = job_i.diff_y;
          diff_d[2]   = job_i.diff_z;
          vec_d[0]    = job_i.diff_x;
          vec_d[1]    = job_i.diff_y;
          vec_d[2]    = job_i.diff_z;
          w_d         = job_i.half_width;
          cnt_d       = job_i.count;
          axis_mode_d = 1'b1;
          state_d     = ST_MAG;
        end
      end
      ST_MAG: begin
        top_d = '0;
        for (int n = 0; n < 3; n++) begin
          m_d[n] = vec_q[n][32] ? 33'(-vec_q[n]) : 33'(vec_q[n]);
          if (m_d[n] > top_d) begin
            top_d = m_d[n];
          end
        end
        if (top_d == '0) begin
          // zero vector: unit is zero, flag it
          zero_d = 1'b1;
          for (int n = 0; n < 3; n++) begin
            ures_d[n] = '0;
          end
          state_d = ST_UDONE;
        end else begin
          zero_d  = 1'b0;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (top_q[32:30] != 3'b0) begin
          top_d = top_q >> 1;
          for (int n = 0; n < 3; n++) begin
            m_d[n] = m_q[n] >> 1;
          end
        end else if (!top_q[29]) begin
          top_d = top_q << 1;
          for (int n = 0; n < 3; n++) begin
            m_d[n] = m_q[n] << 1;
          end
        end else begin
          sum_d   = '0;
          k_d     = 2'd0;
          ph_d    = 2'd0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          sum_d = sum_q + prod_q[61:0];
          ph_d  = 2'd0;
          if (k_q == 2'd2) begin
            res_d   = '0;
            bit_d   = 63'd1 << 62;
            state_d = ST_SQRT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_SQRT: begin
        // one result bit per cycle, remainder kept in sum
        if ({2'b0, sum_q} >= rb) begin
          sum_d = sum_q - rb[61:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 63'd1) begin
          k_d     = 2'd0;
          ph_d    = 2'd0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (div_rsp_i.done) begin
          ures_d[k_q] = vec_q[k_q][32] ? -$signed(div_rsp_i.quo[31:0])
                                       : $signed(div_rsp_i.quo[31:0]);
          ph_d = 2'd0;
          if (k_q == 2'd2) begin
            state_d = ST_UDONE;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_UDONE: begin
        k_d  = 2'd0;
        ph_d = 2'd0;
        jx_d = 3'd0;
        if (axis_mode_q) begin
          for (int n = 0; n < 3; n++) begin
            axis_d[n] = ures_q[n];
          end
          i_d     = 5'd0;
          state_d = ST_PMUL;
        end else begin
          state_d = ST_CROSS;
        end
      end
      ST_PMUL: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          pneg_d = prod_q[65];
          ph_d   = 2'd2;
        end else if (div_rsp_i.done) begin
          psum = 34'(s_q[k_q]) + (pneg_q ? -$signed({1'b0, q}) : $signed({1'b0, q}));
          p_d[k_q] = psum[31:0];
          ph_d     = 2'd0;
          if (k_q == 2'd2) begin
            state_d = ST_PDIR;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_PDIR: begin
        for (int n = 0; n < 3; n++) begin
          vec_d[n] = 33'(cam[n]) - 33'(p_q[n]);
        end
        axis_mode_d = 1'b0;
        state_d     = ST_MAG;
      end
      ST_CROSS: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          if (!jx_q[0]) begin
            tmp_d = prod_q[61:0];
          end else begin
            cr_d[jx_q[2:1]] = 33'(shr30_round(xd));
          end
          ph_d = 2'd0;
          if (jx_q == 3'd5) begin
            k_d     = 2'd0;
            state_d = ST_OFF;
          end else begin
            jx_d = jx_q + 3'd1;
          end
        end
      end
      ST_OFF: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          off_d[k_q] = shr30_round(prod_q[63:0]);
          ph_d       = 2'd0;
          if (k_q == 2'd2) begin
            state_d = ST_EMIT0;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_EMIT0, ST_EMIT1: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          for (int n = 0; n < 3; n++) begin
            pv = 36'(p_q[n]);
            ov = 36'(off_q[n]);
            if (state_q == ST_EMIT0) begin
              pv = pv - ov;
            end else begin
              pv = pv + ov;
            end
            case (n)
              0:       out_d.vertex_x = sat32(pv);
              1:       out_d.vertex_y = sat32(pv);
              default: out_d.vertex_z = sat32(pv);
            endcase
          end
          out_d.point_index = i_q;
          out_d.side        = (state_q == ST_EMIT1);
          out_d.degenerate  = zero_q;
          out_d.last        = (state_q == ST_EMIT1) && (i_q == cnt_q);
          if (state_q == ST_EMIT0) begin
            state_d = ST_EMIT1;
          end else if (i_q == cnt_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 5'd1;
            k_d     = 2'd0;
            ph_d    = 2'd0;
            state_d = ST_PMUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 2'd0;
      ph_q        <= 2'd0;
      jx_q        <= 3'd0;
      i_q         <= 5'd0;
      axis_mode_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      ph_q        <= ph_d;
      jx_q        <= jx_d;
      i_q         <= i_d;
      axis_mode_q <= axis_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    zero_q <= zero_d;
    pneg_q <= pneg_d;
    w_q    <= w_d;
    top_q  <= top_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    tmp_q  <= tmp_d;
    prod_q <= prod_d;
    out_q  <= out_d;
    for (int n = 0; n < 3; n++) begin
      s_q[n]    <= s_d[n];
      diff_q[n] <= diff_d[n];
      vec_q[n]  <= vec_d[n];
      m_q[n]    <= m_d[n];
      ures_q[n] <= ures_d[n];
      axis_q[n] <= axis_d[n];
      p_q[n]    <= p_d[n];
      cr_q[n]   <= cr_d[n];
      off_q[n]  <= off_d[n];
    end
  end

endmodule

@@ hw/rtl/beam_ribbon_vertex_generator.sv @@
`timescale 1ns / 1ps
// Top level of the camera-facing beam ribbon vertex generator: camera registers,
// front end, segment queue, back-end sequencer and shared divider. Depends on brvg_pkg.
//
// Each accepted segment beat yields 2*(n+1) vertex beats, n being the segment count
// clamped to 1..31: for every sample point, first the minus-offset vertex, then the
// plus-offset one, with last set on the final beat. The front end takes a new beat
// while the back end is still working, so up to three segments (two queued, one held)
// can wait ahead of the back end. The back end works on one segment at a time and its
// cost is set by the shared 64-step divider: the beam axis needs three unit-vector
// divides (none for a zero-length segment), and each sample point needs three
// interpolation divides, three unit-vector divides, a 32-step square root, up to 29
// normalizing shifts and fifteen multiplies (no square root or unit-vector divides for
// a point on the camera). A vertex beat that is not taken holds the output register
// and stalls the back end. Write the camera registers only while the block is idle;
// writes to an index beyond camera_z are dropped.
module beam_ribbon_vertex_generator import brvg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cam_t     cam_q, cam_d;
  logic     push, full, pop, empty;
  job_t     front_job, queue_job;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // camera position registers
  always_comb begin
    cam_d = cam_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAMERA_X: cam_d.x = cfg_wdata_i;
        CFG_CAMERA_Y: cam_d.y = cfg_wdata_i;
        CFG_CAMERA_Z: cam_d.z = cfg_wdata_i;
        default:      cam_d   = cam_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q <= '0;
    end else begin
      cam_q <= cam_d;
    end
  end

  brvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  brvg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (queue_job)
  );

  brvg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  brvg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cam_i       (cam_q),
    .empty_i     (empty),
    .job_i       (queue_job),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
